FILE: rtl/core/utr_pkg.sv
// Shared types, constants and helpers for the unacked packet tracker.
package utr_pkg;

	localparam int MAX_RES = 64;
	localparam int RES_AW  = 6;
	localparam int RES_CW  = 7;

	typedef enum logic [2:0] {
		FN_ADD       = 3'd0,
		FN_ACK       = 3'd1,
		FN_LOSS      = 3'd2,
		FN_REMOVE    = 3'd3,
		FN_PICK_TO   = 3'd4,
		FN_PICK_LOST = 3'd5,
		FN_QUERY     = 3'd6
	} func_t;

	typedef enum logic [3:0] {
		OP_NONE,
		OP_CLEAR,
		OP_CAPTURE,
		OP_FETCH,
		OP_ADD,
		OP_RD_ENT,
		OP_UNMAP_RD,
		OP_ACK_RED,
		OP_RED,
		OP_WALK_RD,
		OP_WALK_FREE,
		OP_LUP_RD,
		OP_PT_TAKE,
		OP_PL_TAKE,
		OP_RED_INC,
		OP_LUP_INC
	} dp_op_t;

	typedef enum logic [4:0] {
		ST_CLEAR,
		ST_IDLE,
		ST_FETCH,
		ST_DECODE,
		ST_RED,
		ST_QRY,
		ST_WALK_RD,
		ST_WALK,
		ST_PT_CHK,
		ST_PT_M,
		ST_PT_E,
		ST_PL_CHK,
		ST_PL_M,
		ST_PL_RED,
		ST_FIN,
		ST_OUT_RD,
		ST_OUT,
		ST_EMIT
	} state_t;

	typedef struct packed {
		dp_op_t op;
		logic   query;
		logic   out_rd;
		logic   out_next;
		logic   pick_out;
	} cmd_t;

	typedef struct packed {
		func_t func;
		logic  clr_done;
		logic  map_valid;
		logic  ent_valid;
		logic  ent_acked;
		logic  expired;
		logic  at_lus;
		logic  res_full;
		logic  res_none;
		logic  out_last;
		logic  lup_ahead;
		logic  lup_behind;
	} status_t;

	// serial comparison mod 2^16: a is newer than b
	function automatic logic newer(input logic [15:0] a, input logic [15:0] b);
		logic [15:0] d;
		d = a - b;
		return (d != 16'd0) && !d[15];
	endfunction

endpackage

FILE: rtl/core/utr_ctrl.sv
// Sequencing state machine of the unacked packet tracker.
module utr_ctrl
	import utr_pkg::*;
(
	input  logic    clk,
	input  logic    arst_n,
	input  logic    start,
	input  status_t status,
	output cmd_t    cmd,
	output logic    busy,
	output logic    strobe
);

	state_t state_q, state_nx;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_CLEAR;
		end else begin
			state_q <= state_nx;
		end
	end

	always_comb begin
		state_nx = state_q;
		case (state_q)
			ST_CLEAR: begin
				if (status.clr_done) state_nx = ST_IDLE;
			end
			ST_IDLE: begin
				if (start) state_nx = ST_FETCH;
			end
			ST_FETCH: state_nx = ST_DECODE;
			ST_DECODE: begin
				case (status.func)
					FN_ADD: state_nx = ST_EMIT;
					FN_ACK, FN_LOSS, FN_REMOVE:
						state_nx = status.map_valid ? ST_RED : ST_EMIT;
					FN_QUERY: state_nx = status.map_valid ? ST_QRY : ST_EMIT;
					FN_PICK_TO: state_nx = ST_PT_CHK;
					FN_PICK_LOST: state_nx = status.lup_ahead ? ST_EMIT : ST_PL_CHK;
					default: state_nx = ST_EMIT;
				endcase
			end
			ST_RED: begin
				if (status.func == FN_ACK && status.at_lus) state_nx = ST_WALK_RD;
				else state_nx = ST_EMIT;
			end
			ST_QRY: state_nx = ST_EMIT;
			ST_WALK_RD: state_nx = ST_WALK;
			ST_WALK: begin
				if (status.ent_valid && status.ent_acked) state_nx = ST_WALK_RD;
				else state_nx = ST_EMIT;
			end
			ST_PT_CHK: state_nx = status.res_full ? ST_FIN : ST_PT_M;
			ST_PT_M: state_nx = status.map_valid ? ST_PT_E : ST_FIN;
			ST_PT_E: begin
				if (status.ent_acked || !status.expired) state_nx = ST_FIN;
				else state_nx = ST_PT_CHK;
			end
			ST_PL_CHK: begin
				if (status.res_full || !status.lup_behind) state_nx = ST_FIN;
				else state_nx = ST_PL_M;
			end
			ST_PL_M: state_nx = status.map_valid ? ST_PL_RED : ST_PL_CHK;
			ST_PL_RED: state_nx = ST_PL_CHK;
			ST_FIN: state_nx = status.res_none ? ST_EMIT : ST_OUT_RD;
			ST_OUT_RD: state_nx = ST_OUT;
			ST_OUT: state_nx = status.out_last ? ST_IDLE : ST_OUT_RD;
			ST_EMIT: state_nx = ST_IDLE;
			default: state_nx = ST_IDLE;
		endcase
	end

	always_comb begin
		cmd      = '{op: OP_NONE, query: 1'b0, out_rd: 1'b0, out_next: 1'b0,
			pick_out: 1'b0};
		busy     = (state_q != ST_IDLE);
		strobe   = 1'b0;
		case (state_q)
			ST_CLEAR: cmd.op = OP_CLEAR;
			ST_IDLE: begin
				if (start) cmd.op = OP_CAPTURE;
			end
			ST_FETCH: cmd.op = OP_FETCH;
			ST_DECODE: begin
				case (status.func)
					FN_ADD: cmd.op = OP_ADD;
					FN_ACK, FN_LOSS, FN_REMOVE: begin
						if (status.map_valid) cmd.op = OP_UNMAP_RD;
					end
					FN_QUERY: begin
						if (status.map_valid) cmd.op = OP_RD_ENT;
						else cmd.query = 1'b1;
					end
					default: cmd.op = OP_NONE;
				endcase
			end
			ST_RED: cmd.op = (status.func == FN_ACK) ? OP_ACK_RED : OP_RED;
			ST_QRY: cmd.query = 1'b1;
			ST_WALK_RD: cmd.op = OP_WALK_RD;
			ST_WALK: begin
				if (status.ent_valid && status.ent_acked) cmd.op = OP_WALK_FREE;
			end
			ST_PT_CHK: begin
				if (!status.res_full) cmd.op = OP_LUP_RD;
			end
			ST_PT_M: begin
				if (status.map_valid) cmd.op = OP_RD_ENT;
			end
			ST_PT_E: begin
				if (!status.ent_acked && status.expired) cmd.op = OP_PT_TAKE;
			end
			ST_PL_CHK: begin
				if (!status.res_full && status.lup_behind) cmd.op = OP_LUP_RD;
			end
			ST_PL_M: cmd.op = status.map_valid ? OP_PL_TAKE : OP_LUP_INC;
			ST_PL_RED: cmd.op = OP_RED_INC;
			ST_OUT_RD: cmd.out_rd = 1'b1;
			ST_OUT: begin
				cmd.out_next = 1'b1;
				cmd.pick_out = 1'b1;
				strobe       = 1'b1;
			end
			ST_EMIT: strobe = 1'b1;
			default: cmd.op = OP_NONE;
		endcase
	end

endmodule

FILE: rtl/core/utr_dp.sv
// Tables, counters and result buffer of the unacked packet tracker.
module utr_dp
	import utr_pkg::*;
#(
	parameter int PACKET_SLOTS = 64,
	parameter int SEQ_SLOTS    = 256
) (
	input  logic        clk,
	input  logic        arst_n,
	input  cmd_t        cmd,
	input  logic [2:0]  func,
	input  logic [15:0] pkt_num,
	input  logic [15:0] seq_num,
	input  logic [15:0] pkt_len,
	input  logic [47:0] time_us,
	input  logic [31:0] timeout_span,
	output status_t     status,
	output logic        found,
	output logic [15:0] out_seq,
	output logic        last_item,
	output logic        entry_acked,
	output logic [15:0] entry_bytes,
	output logic [31:0] flight_bytes,
	output logic [15:0] flight_packets,
	output logic [15:0] least_unacked_pkt
);

	localparam int PB    = $clog2(PACKET_SLOTS);
	localparam int SB    = $clog2(SEQ_SLOTS);
	localparam int CLR_N = (PACKET_SLOTS > SEQ_SLOTS) ? PACKET_SLOTS : SEQ_SLOTS;
	localparam int CW    = $clog2(CLR_N);

	// map entry: valid, seq; seq entry: valid, acked, length
	logic [16:0] map_mem [PACKET_SLOTS];
	logic [17:0] ent_mem [SEQ_SLOTS];
	logic [47:0] time_mem [SEQ_SLOTS];
	logic [15:0] res_mem [MAX_RES];

	logic [16:0] map_rd_q;
	logic [17:0] ent_rd_q;
	logic [47:0] time_rd_q;
	logic [15:0] res_rd_q;
	logic [PB-1:0] map_ra_q;

	func_t       func_q;
	logic [15:0] pkt_q, seq_q, len_q, s_q;
	logic [47:0] now_q;
	logic [31:0] span_q;
	logic        qfound_q, qacked_q;
	logic [15:0] qseq_q, qbytes_q;

	logic [15:0] lus_q, lup_q, pkts_q;
	logic [31:0] bytes_q;
	logic [CW-1:0] clr_q;
	logic [RES_CW-1:0] n_q;
	logic [RES_AW-1:0] k_q;

	logic [15:0] mseq, ent_len;
	logic [31:0] red_bytes, add_bytes;
	logic [32:0] add_sum;
	logic [15:0] red_pkts, add_pkts;
	logic [47:0] age;

	logic          map_we, map_re, ent_we, ent_re, time_we, res_we;
	logic [PB-1:0] map_wa, map_ra;
	logic [SB-1:0] ent_wa, ent_ra;
	logic [16:0]   map_wd;
	logic [17:0]   ent_wd;
	logic [15:0]   res_wd;

	assign mseq    = map_rd_q[15:0];
	assign ent_len = ent_rd_q[15:0];

	assign red_bytes = (bytes_q >= {16'd0, ent_len}) ? bytes_q - {16'd0, ent_len} : 32'd0;
	assign red_pkts  = (pkts_q != 16'd0) ? pkts_q - 16'd1 : 16'd0;
	assign add_sum   = {1'b0, bytes_q} + {17'd0, len_q};
	assign add_bytes = add_sum[32] ? 32'hFFFF_FFFF : add_sum[31:0];
	assign add_pkts  = (pkts_q != 16'hFFFF) ? pkts_q + 16'd1 : pkts_q;
	assign age       = now_q - time_rd_q;

	always_comb begin
		map_we  = 1'b0;
		map_wa  = map_ra_q;
		map_wd  = '0;
		ent_we  = 1'b0;
		ent_wa  = s_q[SB-1:0];
		ent_wd  = '0;
		time_we = 1'b0;
		res_we  = 1'b0;
		res_wd  = mseq;
		case (cmd.op)
			OP_CLEAR: begin
				map_we = 1'b1;
				map_wa = clr_q[PB-1:0];
				ent_we = 1'b1;
				ent_wa = clr_q[SB-1:0];
			end
			OP_ADD: begin
				map_we  = 1'b1;
				map_wd  = {1'b1, seq_q};
				time_we = 1'b1;
				ent_wa  = seq_q[SB-1:0];
				// a retransmission keeps the stored length and acked bit
				if (!ent_rd_q[17]) begin
					ent_we = 1'b1;
					ent_wd = {2'b10, len_q};
				end
			end
			OP_UNMAP_RD: map_we = 1'b1;
			OP_ACK_RED: begin
				ent_we = 1'b1;
				ent_wd = ent_rd_q | 18'h1_0000;
			end
			OP_WALK_FREE: begin
				ent_we = 1'b1;
				ent_wa = lus_q[SB-1:0];
			end
			OP_PT_TAKE: begin
				res_we = 1'b1;
				res_wd = s_q;
				map_we = 1'b1;
			end
			OP_PL_TAKE: begin
				res_we = 1'b1;
				map_we = 1'b1;
			end
			default: map_we = 1'b0;
		endcase
	end

	always_comb begin
		map_re = (cmd.op == OP_FETCH) || (cmd.op == OP_LUP_RD);
		map_ra = (cmd.op == OP_FETCH) ? pkt_q[PB-1:0] : lup_q[PB-1:0];
		ent_re = 1'b1;
		ent_ra = mseq[SB-1:0];
		case (cmd.op)
			OP_FETCH: ent_ra = seq_q[SB-1:0];
			OP_WALK_RD: ent_ra = lus_q[SB-1:0];
			OP_RD_ENT, OP_UNMAP_RD, OP_PL_TAKE: ent_ra = mseq[SB-1:0];
			default: ent_re = 1'b0;
		endcase
	end

	always_ff @(posedge clk) begin
		if (map_we) map_mem[map_wa] <= map_wd;
		if (ent_we) ent_mem[ent_wa] <= ent_wd;
		if (time_we) time_mem[seq_q[SB-1:0]] <= now_q;
		if (res_we) res_mem[n_q[RES_AW-1:0]] <= res_wd;
	end

	always_ff @(posedge clk) begin
		if (map_re) begin
			map_rd_q <= map_mem[map_ra];
			map_ra_q <= map_ra;
		end
		if (ent_re) begin
			ent_rd_q  <= ent_mem[ent_ra];
			time_rd_q <= time_mem[ent_ra];
		end
		if (cmd.out_rd) res_rd_q <= res_mem[k_q];
	end

	always_ff @(posedge clk) begin
		if (cmd.op == OP_CAPTURE) begin
			func_q   <= func_t'(func);
			pkt_q    <= pkt_num;
			seq_q    <= seq_num;
			len_q    <= pkt_len;
			now_q    <= time_us;
			span_q   <= timeout_span;
			qfound_q <= 1'b0;
			qseq_q   <= 16'd0;
			qacked_q <= 1'b0;
			qbytes_q <= 16'd0;
		end
		if (cmd.op == OP_RD_ENT || cmd.op == OP_UNMAP_RD || cmd.op == OP_PL_TAKE) begin
			s_q <= mseq;
		end
		if (cmd.query) begin
			if (map_rd_q[16]) begin
				qfound_q <= 1'b1;
				qseq_q   <= mseq;
				qacked_q <= !ent_rd_q[17] || ent_rd_q[16];
				qbytes_q <= ent_len;
			end else begin
				qacked_q <= 1'b1;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			lus_q   <= '0;
			lup_q   <= '0;
			bytes_q <= '0;
			pkts_q  <= '0;
			clr_q   <= '0;
			n_q     <= '0;
			k_q     <= '0;
		end else begin
			case (cmd.op)
				OP_CLEAR: clr_q <= clr_q + 1'b1;
				OP_CAPTURE: begin
					n_q <= '0;
					k_q <= '0;
				end
				OP_ADD: begin
					bytes_q <= add_bytes;
					pkts_q  <= add_pkts;
				end
				OP_ACK_RED, OP_RED: begin
					bytes_q <= red_bytes;
					pkts_q  <= red_pkts;
				end
				OP_WALK_FREE: lus_q <= lus_q + 16'd1;
				OP_PT_TAKE: begin
					n_q     <= n_q + 1'b1;
					bytes_q <= red_bytes;
					pkts_q  <= red_pkts;
					lup_q   <= lup_q + 16'd1;
				end
				OP_PL_TAKE: n_q <= n_q + 1'b1;
				OP_RED_INC: begin
					bytes_q <= red_bytes;
					pkts_q  <= red_pkts;
					lup_q   <= lup_q + 16'd1;
				end
				OP_LUP_INC: lup_q <= lup_q + 16'd1;
				default: clr_q <= clr_q;
			endcase
			if (cmd.out_next) k_q <= k_q + 1'b1;
		end
	end

	always_comb begin
		status.func       = func_q;
		status.clr_done   = (clr_q == CW'(CLR_N - 1));
		status.map_valid  = map_rd_q[16];
		status.ent_valid  = ent_rd_q[17];
		status.ent_acked  = ent_rd_q[16];
		status.expired    = (age >= {16'd0, span_q});
		status.at_lus     = (lus_q == s_q);
		status.res_full   = (n_q == RES_CW'(MAX_RES));
		status.res_none   = (n_q == '0);
		status.out_last   = (({1'b0, k_q} + 1'b1) == n_q);
		status.lup_ahead  = newer(lup_q, pkt_q);
		status.lup_behind = newer(pkt_q, lup_q);
	end

	assign found             = cmd.pick_out ? 1'b1 : qfound_q;
	assign out_seq           = cmd.pick_out ? res_rd_q : qseq_q;
	assign last_item         = cmd.pick_out ? status.out_last : 1'b1;
	assign entry_acked       = cmd.pick_out ? 1'b0 : qacked_q;
	assign entry_bytes       = cmd.pick_out ? 16'd0 : qbytes_q;
	assign flight_bytes      = bytes_q;
	assign flight_packets    = pkts_q;
	assign least_unacked_pkt = lup_q;

endmodule

FILE: rtl/core/unacked_packet_tracker.sv
// Sent-packet scoreboard: packet map, sequence table, flight counters, loss picks.
// Add, no-op, unmapped: fetch, decode, result; mapped adds a reduce or query step.
// Ack walk: read and free per freed entry, plus a read of the entry that ends it.
// Picks: check, map read, entry or reduce per packet; then read and send per result.
// After reset a clearing pass over max(PACKET_SLOTS, SEQ_SLOTS) slots holds busy high.
// Slot counts must be powers of two, unchecked; the receiver cannot stall results.
module unacked_packet_tracker
	import utr_pkg::*;
#(
	parameter int PACKET_SLOTS = 64,
	parameter int SEQ_SLOTS    = 256
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        start,
	output logic        busy,
	input  logic [2:0]  func,
	input  logic [15:0] pkt_num,
	input  logic [15:0] seq_num,
	input  logic [15:0] pkt_len,
	input  logic [47:0] time_us,
	input  logic [31:0] timeout_span,
	output logic        strobe,
	output logic        found,
	output logic [15:0] out_seq,
	output logic        last_item,
	output logic        entry_acked,
	output logic [15:0] entry_bytes,
	output logic [31:0] flight_bytes,
	output logic [15:0] flight_packets,
	output logic [15:0] least_unacked_pkt
);

	cmd_t    cmd;
	status_t status;

	utr_ctrl u_ctrl (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (start),
		.status (status),
		.cmd    (cmd),
		.busy   (busy),
		.strobe (strobe)
	);

	utr_dp #(
		.PACKET_SLOTS (PACKET_SLOTS),
		.SEQ_SLOTS    (SEQ_SLOTS)
	) u_dp (
		.clk               (clk),
		.arst_n            (arst_n),
		.cmd               (cmd),
		.func              (func),
		.pkt_num           (pkt_num),
		.seq_num           (seq_num),
		.pkt_len           (pkt_len),
		.time_us           (time_us),
		.timeout_span      (timeout_span),
		.status            (status),
		.found             (found),
		.out_seq           (out_seq),
		.last_item         (last_item),
		.entry_acked       (entry_acked),
		.entry_bytes       (entry_bytes),
		.flight_bytes      (flight_bytes),
		.flight_packets    (flight_packets),
		.least_unacked_pkt (least_unacked_pkt)
	);

`ifndef SYNTHESIS
	a_strobe_busy: assert property (@(posedge clk) disable iff (!arst_n)
		strobe |-> busy) else $error("result strobe outside a request");
	a_last_frees: assert property (@(posedge clk) disable iff (!arst_n)
		strobe && last_item |=> !busy) else $error("not idle after final result");
	a_more_follows: assert property (@(posedge clk) disable iff (!arst_n)
		strobe && !last_item |=> busy) else $error("request ended before final result");
	a_pick_found: assert property (@(posedge clk) disable iff (!arst_n)
		strobe && !last_item |-> found) else $error("non-final result without lost seq");
`endif

endmodule

FILE: dv/unacked_packet_tracker_tb.sv
// Self-checking testbench for the unacked packet tracker: directed cases, random traffic.
module unacked_packet_tracker_tb;
	import utr_pkg::*;

	localparam int WDOG_LIMIT = 400000;

	typedef struct {
		bit        found;
		bit [15:0] oseq;
		bit        last;
		bit        acked;
		bit [15:0] bytes;
		bit [31:0] fbytes;
		bit [15:0] fpkts;
		bit [15:0] lup;
	} track_res_t;

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        start = 1'b0;
	logic        busy;
	logic [2:0]  func = '0;
	logic [15:0] pkt_num = '0;
	logic [15:0] seq_num = '0;
	logic [15:0] pkt_len = '0;
	logic [47:0] time_us = '0;
	logic [31:0] timeout_span = '0;
	logic        strobe;
	logic        found;
	logic [15:0] out_seq;
	logic        last_item;
	logic        entry_acked;
	logic [15:0] entry_bytes;
	logic [31:0] flight_bytes;
	logic [15:0] flight_packets;
	logic [15:0] least_unacked_pkt;

	unacked_packet_tracker u_top (.*);

	always #1 clk = ~clk;

	// shadow scoreboard state
	bit [16:0] sh_map[64];
	bit        sh_valid[256];
	bit        sh_acked[256];
	bit [15:0] sh_len[256];
	bit [47:0] sh_time[256];
	bit [15:0] sh_lus, sh_lup, sh_lap, sh_pkts;
	bit [31:0] sh_bytes;

	track_res_t pending_res[$];
	int  errors = 0;
	bit  idle_on = 1'b1;
	bit [15:0] next_pkt = 0, next_seq = 0;
	bit [47:0] clock_us = 48'd100;

	function automatic bit is_newer(bit [15:0] a, bit [15:0] b);
		bit [15:0] d;
		d = a - b;
		return (d != 0) && !d[15];
	endfunction

	function automatic void drop_flight(bit [15:0] s);
		bit [15:0] l;
		l = sh_len[s[7:0]];
		sh_bytes = (sh_bytes >= l) ? sh_bytes - l : 32'd0;
		if (sh_pkts > 0) sh_pkts--;
	endfunction

	function automatic void tracker_step(bit [2:0] f, bit [15:0] p, bit [15:0] s,
			bit [15:0] l, bit [47:0] t, bit [31:0] sp);
		track_res_t r[$];
		track_res_t one;
		bit [16:0] m;
		bit [7:0]  e;
		bit [32:0] sum;
		int i;
		one = '{default: 0};
		case (f)
			FN_ADD: begin
				e = s[7:0];
				sh_map[p[5:0]] = {1'b1, s};
				if (!sh_valid[e]) begin
					sh_valid[e] = 1; sh_acked[e] = 0; sh_len[e] = l;
				end
				sum = {1'b0, sh_bytes} + l;
				sh_bytes = sum[32] ? 32'hFFFF_FFFF : sum[31:0];
				if (sh_pkts != 16'hFFFF) sh_pkts++;
				sh_time[e] = t;
				r = {r, one};
			end
			FN_ACK: begin
				m = sh_map[p[5:0]];
				sh_lap = p;
				if (m[16]) begin
					sh_map[p[5:0]] = 0;
					sh_acked[m[7:0]] = 1;
					drop_flight(m[15:0]);
					if (sh_lus == m[15:0]) begin
						for (i = 0; i < 256; i++) begin
							e = sh_lus[7:0];
							if (!(sh_valid[e] && sh_acked[e])) break;
							sh_valid[e] = 0; sh_acked[e] = 0; sh_len[e] = 0;
							sh_lus++;
						end
					end
				end
				r = {r, one};
			end
			FN_LOSS, FN_REMOVE: begin
				m = sh_map[p[5:0]];
				if (m[16]) begin
					sh_map[p[5:0]] = 0;
					drop_flight(m[15:0]);
				end
				r = {r, one};
			end
			FN_PICK_TO: begin
				while (r.size() < MAX_RES) begin
					m = sh_map[sh_lup[5:0]];
					if (!m[16]) break;
					e = m[7:0];
					if (sh_acked[e] || ((t - sh_time[e]) < {16'd0, sp})) break;
					one.found = 1; one.oseq = m[15:0];
					r = {r, one};
					drop_flight(m[15:0]);
					sh_map[sh_lup[5:0]] = 0;
					sh_lup++;
				end
				one = '{default: 0};
				if (r.size() == 0) r = {r, one};
			end
			FN_PICK_LOST: begin
				if (!is_newer(sh_lup, p)) begin
					while (r.size() < MAX_RES && is_newer(p, sh_lup)) begin
						m = sh_map[sh_lup[5:0]];
						if (m[16]) begin
							one.found = 1; one.oseq = m[15:0];
							r = {r, one};
							drop_flight(m[15:0]);
							sh_map[sh_lup[5:0]] = 0;
						end
						sh_lup++;
					end
				end
				one = '{default: 0};
				if (r.size() == 0) r = {r, one};
			end
			FN_QUERY: begin
				m = sh_map[p[5:0]];
				if (m[16]) begin
					e = m[7:0];
					one.found = 1; one.oseq = m[15:0];
					one.acked = sh_valid[e] ? sh_acked[e] : 1'b1;
					one.bytes = sh_len[e];
				end else begin
					one.acked = 1;
				end
				r = {r, one};
			end
			default: r = {r, one};
		endcase
		foreach (r[k]) begin
			r[k].last = (k == r.size() - 1);
			r[k].fbytes = sh_bytes;
			r[k].fpkts = sh_pkts;
			r[k].lup = sh_lup;
			pending_res = {pending_res, r[k]};
		end
	endfunction

	// one request; called right after a rising edge, returns at the accepting edge
	task automatic send_req(bit [2:0] f, bit [15:0] p, bit [15:0] s, bit [15:0] l,
			bit [47:0] t, bit [31:0] sp);
		if (idle_on && $urandom_range(0, 3) == 0) begin
			if (start) start <= 1'b0;
			repeat ($urandom_range(1, 16)) @(posedge clk);
			start <= 1'b1;
		end else if (!start) begin
			start <= 1'b1;
		end
		func <= f; pkt_num <= p; seq_num <= s; pkt_len <= l;
		time_us <= t; timeout_span <= sp;
		do @(posedge clk); while (busy);
		tracker_step(f, p, s, l, t, sp);
	endtask

	task automatic add_pkt(bit [15:0] len);
		clock_us += $urandom_range(1, 50);
		send_req(FN_ADD, next_pkt, next_seq, len, clock_us, $urandom);
		next_pkt++; next_seq++;
	endtask

	task automatic check_field(string name, logic [47:0] e, logic [47:0] a);
		if (e !== a) begin
			$error("%s mismatch: expected %0h, actual %0h", name, e, a);
			errors++;
		end
	endtask

	always @(posedge clk) begin
		track_res_t x;
		if (arst_n && strobe) begin
			if (pending_res.size() == 0) begin
				$error("result with no request outstanding");
				errors++;
			end else begin
				x = pending_res.pop_front();
				check_field("found", x.found, found);
				check_field("out_seq", x.oseq, out_seq);
				check_field("last_item", x.last, last_item);
				check_field("entry_acked", x.acked, entry_acked);
				check_field("entry_bytes", x.bytes, entry_bytes);
				check_field("flight_bytes", x.fbytes, flight_bytes);
				check_field("flight_packets", x.fpkts, flight_packets);
				check_field("least_unacked_pkt", x.lup, least_unacked_pkt);
			end
		end
	end

	int quiet = 0;
	always @(posedge clk) begin
		if ((start && !busy) || strobe || !arst_n) begin
			quiet <= 0;
		end else if (quiet >= WDOG_LIMIT) begin
			$display("unacked_packet_tracker test failed");
			$finish;
		end else begin
			quiet <= quiet + 1;
		end
	end

	task automatic test_basic_ops();
		send_req(FN_QUERY, 16'd0, 0, 0, 0, 0);
		add_pkt(16'hFFFF);
		clock_us = 48'hFFFF_FFFF_FFF0;
		add_pkt(16'd0);
		send_req(FN_QUERY, 16'd0, 0, 0, 0, 0);
		send_req(FN_QUERY, 16'hFFFF, 16'hFFFF, 16'hFFFF, '1, '1);
		send_req(FN_ACK, 16'd1, 0, 0, 0, 0);
		send_req(FN_QUERY, 16'd1, 0, 0, 0, 0);
		send_req(FN_ACK, 16'd0, 0, 0, 0, 0);
		send_req(FN_ACK, 16'h1234, 0, 0, 0, 0);
		send_req(3'd7, 16'hFFFF, 16'hFFFF, 16'hFFFF, '1, '1);
		clock_us = 48'd10;
	endtask

	task automatic test_retransmit_and_drops();
		add_pkt(16'd100);
		// same sequence again with zero length: stored length kept, drops clamp at zero
		send_req(FN_ADD, next_pkt, next_seq - 16'd1, 16'd0, clock_us, 0);
		next_pkt++;
		send_req(FN_QUERY, next_pkt - 16'd1, 0, 0, 0, 0);
		send_req(FN_LOSS, next_pkt - 16'd2, 0, 0, 0, 0);
		send_req(FN_REMOVE, next_pkt - 16'd1, 0, 0, 0, 0);
		send_req(FN_REMOVE, 16'hBEEF, 0, 0, 0, 0);
		// map slot overwrite: same slot, different packet number
		add_pkt(16'd7);
		send_req(FN_ADD, next_pkt + 16'd63, next_seq, 16'd9, clock_us, 0);
		next_seq++;
	endtask

	task automatic test_picks();
		send_req(FN_PICK_LOST, next_pkt, 0, 0, 0, 0);
		send_req(FN_PICK_TO, 0, 0, 0, clock_us, 0);
		repeat (4) add_pkt($urandom);
		send_req(FN_PICK_TO, 0, 0, 0, clock_us, 32'hFFFF_FFFF);
		send_req(FN_PICK_TO, 0, 0, 0, clock_us + 48'd60, 32'd60);
		// clock wrap: now below send time
		send_req(FN_PICK_TO, 0, 0, 0, 48'd0, 32'd5);
		send_req(FN_PICK_LOST, sh_lup - 16'd1, 0, 0, 0, 0);
		send_req(FN_PICK_LOST, next_pkt, 0, 0, 0, 0);
	endtask

	task automatic test_result_limit();
		repeat (66) add_pkt($urandom_range(0, 2000));
		send_req(FN_PICK_LOST, next_pkt, 0, 0, 0, 0);
		send_req(FN_PICK_LOST, next_pkt, 0, 0, 0, 0);
		// one long walk over an empty map
		send_req(FN_PICK_LOST, sh_lup + 16'h7FFF, 0, 0, 0, 0);
		next_pkt = sh_lup;
	endtask

	task automatic test_random(int count);
		bit [15:0] span, p;
		repeat (count) begin
			span = next_pkt - sh_lup;
			if (span > 16'd48) begin
				send_req(FN_PICK_LOST, next_pkt, 0, 0, 0, 0);
			end else if ($urandom_range(0, 9) == 0) begin
				p = $urandom;
				case ($urandom_range(0, 2))
					0: send_req(3'($urandom_range(0, 7) == 0 ? 7 : $urandom_range(0, 6) & 3),
						p, $urandom, $urandom, {$urandom, $urandom}, $urandom);
					1: send_req(FN_QUERY, p, $urandom, $urandom, {$urandom, $urandom}, $urandom);
					default: send_req(FN_PICK_TO, p, $urandom, $urandom,
						{$urandom, $urandom}, $urandom);
				endcase
			end else begin
				p = sh_lup + 16'($urandom_range(0, span + 1));
				case ($urandom_range(0, 9))
					0, 1, 2: add_pkt($urandom);
					3, 4: send_req(FN_ACK, p, $urandom, $urandom, {$urandom, $urandom}, $urandom);
					5: send_req(FN_LOSS, p, $urandom, $urandom, 0, 0);
					6: send_req(FN_REMOVE, p, $urandom, $urandom, 0, 0);
					7: send_req(FN_PICK_TO, p, 0, 0, clock_us + $urandom_range(0, 100),
						$urandom_range(0, 200));
					8: send_req(FN_PICK_LOST, p, 0, 0, 0, 0);
					default: send_req(FN_QUERY, p, 0, 0, 0, 0);
				endcase
			end
		end
	endtask

	initial begin
		foreach (sh_map[i]) sh_map[i] = 0;
		foreach (sh_valid[i]) begin
			sh_valid[i] = 0; sh_acked[i] = 0; sh_len[i] = 0; sh_time[i] = 0;
		end
		sh_lus = 0; sh_lup = 0; sh_lap = 0; sh_pkts = 0; sh_bytes = 0;
		repeat (8) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		test_basic_ops();
		test_retransmit_and_drops();
		test_picks();
		test_result_limit();
		test_random(14);
		idle_on = 1'b0;
		test_random(8);
		start <= 1'b0;
		while (pending_res.size() != 0) @(posedge clk);
		repeat (600) @(posedge clk);
		if (errors == 0 && pending_res.size() == 0) begin
			$display("unacked_packet_tracker test passed");
		end else begin
			$display("unacked_packet_tracker test failed");
		end
		$finish;
	end

endmodule
